FILE: hw/rtl/rlp_pkg.sv
// shared types and constants of the request line parser
`default_nettype none

package rlp_pkg;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;

   localparam int METHOD_LIMIT_BITS = 7;
   localparam int PATH_LIMIT_BITS   = 13;
   localparam int CSR_DATA_BITS     = 13;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int OFFSET_BITS       = 16;

   localparam logic [METHOD_LIMIT_BITS-1:0] METHOD_LIMIT_RESET = 7'd16;
   localparam logic [PATH_LIMIT_BITS-1:0]   PATH_LIMIT_RESET   = 13'd1024;
   localparam logic [PATH_LIMIT_BITS-1:0]   QUERY_LIMIT_RESET  = 13'd1024;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_METHOD_LIMIT = 2'd0,
      CSR_PATH_LIMIT   = 2'd1,
      CSR_QUERY_LIMIT  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      SEG_METHOD  = 2'd0,
      SEG_PATH    = 2'd1,
      SEG_QUERY   = 2'd2,
      SEG_VERSION = 2'd3
   } segment_type;

   typedef enum logic [1:0] {
      VERDICT_PATH      = 2'd0,
      VERDICT_QUERY     = 2'd1,
      VERDICT_MALFORMED = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [METHOD_LIMIT_BITS-1:0] method_limit;
      logic [PATH_LIMIT_BITS-1:0]   path_limit;
      logic [PATH_LIMIT_BITS-1:0]   query_limit;
   } limits_type;

   typedef struct packed {
      logic [7:0]             out_byte;
      segment_type            segment;
      logic [OFFSET_BITS-1:0] seg_offset;
      logic                   final_res;
      verdict_type            verdict;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rlp_csr.sv
// limit registers of the request line parser
`default_nettype none

module rlp_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rlp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rlp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output rlp_pkg::limits_type                     limits
);

   rlp_pkg::limits_type limits_ff;
   rlp_pkg::limits_type limits_in;

   assign csr_ready = 1'b1;
   assign limits    = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rlp_pkg::CSR_METHOD_LIMIT: begin
               limits_in.method_limit = csr_wdata[rlp_pkg::METHOD_LIMIT_BITS-1:0];
            end
            rlp_pkg::CSR_PATH_LIMIT: begin
               limits_in.path_limit = csr_wdata[rlp_pkg::PATH_LIMIT_BITS-1:0];
            end
            rlp_pkg::CSR_QUERY_LIMIT: begin
               limits_in.query_limit = csr_wdata[rlp_pkg::PATH_LIMIT_BITS-1:0];
            end
            default: begin
               // unmapped index, write dropped
               limits_in = limits_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.method_limit <= rlp_pkg::METHOD_LIMIT_RESET;
         limits_ff.path_limit   <= rlp_pkg::PATH_LIMIT_RESET;
         limits_ff.query_limit  <= rlp_pkg::QUERY_LIMIT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rlp_parse_core.sv
// per-line parse state and labelling of one byte
`default_nettype none

module rlp_parse_core #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          line_byte,
   input  wire logic                line_end,
   input  wire rlp_pkg::limits_type limits,
   output rlp_pkg::result_type      result
);

   localparam int WIDE_BITS = 33;

   typedef enum logic [1:0] {
      PH_METHOD  = 2'd0,
      PH_PATH    = 2'd1,
      PH_QUERY   = 2'd2,
      PH_VERSION = 2'd3
   } phase_type;

   phase_type              phase_ff;
   phase_type              phase_in;
   logic [LENGTH_BITS-1:0] seg_count_ff;
   logic [LENGTH_BITS-1:0] seg_count_in;
   logic                   saw_question_ff;
   logic                   saw_question_in;
   logic                   bad_line_ff;
   logic                   bad_line_in;

   logic [LENGTH_BITS-1:0] count_inc;
   logic [WIDE_BITS-1:0]   count_wide;
   logic                   count_zero;
   logic                   method_bad;
   logic                   path_bad;
   logic                   query_bad;
   logic                   is_space;
   logic                   is_question;
   logic [rlp_pkg::OFFSET_BITS-1:0] count_off;

   assign is_space    = (line_byte == rlp_pkg::CHAR_SPACE);
   assign is_question = (line_byte == rlp_pkg::CHAR_QUESTION);
   assign count_inc   = (&seg_count_ff) ? seg_count_ff : seg_count_ff + 1'b1;
   assign count_wide  = WIDE_BITS'(seg_count_ff);
   assign count_zero  = (seg_count_ff == '0);
   assign method_bad  = count_zero || (count_wide >= WIDE_BITS'(limits.method_limit));
   assign path_bad    = count_zero || (count_wide >= WIDE_BITS'(limits.path_limit));
   assign query_bad   = count_zero || (count_wide >= WIDE_BITS'(limits.query_limit));
   // offset port is 16 bits, clip a wider counter
   assign count_off   = (count_wide > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF
                                                            : count_wide[15:0];

   always_comb begin
      phase_in        = phase_ff;
      seg_count_in    = seg_count_ff;
      saw_question_in = saw_question_ff;
      bad_line_in     = bad_line_ff;
      result.out_byte   = line_byte;
      result.segment    = rlp_pkg::SEG_VERSION;
      result.seg_offset = '0;
      result.final_res  = line_end;
      result.verdict    = rlp_pkg::VERDICT_PATH;

      unique case (phase_ff)
         PH_METHOD: begin
            if (is_space) begin
               bad_line_in  = bad_line_ff | method_bad;
               phase_in     = PH_PATH;
               seg_count_in = '0;
            end else begin
               result.segment    = rlp_pkg::SEG_METHOD;
               result.seg_offset = count_off;
               seg_count_in      = count_inc;
            end
         end
         PH_PATH: begin
            if (is_space) begin
               bad_line_in  = bad_line_ff | path_bad;
               phase_in     = PH_VERSION;
               seg_count_in = LENGTH_BITS'(1);
            end else if (is_question) begin
               bad_line_in     = bad_line_ff | path_bad;
               saw_question_in = 1'b1;
               phase_in        = PH_QUERY;
               seg_count_in    = '0;
            end else begin
               result.segment    = rlp_pkg::SEG_PATH;
               result.seg_offset = count_off;
               seg_count_in      = count_inc;
            end
         end
         PH_QUERY: begin
            if (is_space) begin
               bad_line_in  = bad_line_ff | query_bad;
               phase_in     = PH_VERSION;
               seg_count_in = LENGTH_BITS'(1);
            end else begin
               result.segment    = rlp_pkg::SEG_QUERY;
               result.seg_offset = count_off;
               seg_count_in      = count_inc;
            end
         end
         PH_VERSION: begin
            result.seg_offset = count_off;
            seg_count_in      = count_inc;
         end
         default: begin
            phase_in = PH_METHOD;
         end
      endcase

      if (line_end) begin
         if (phase_in != PH_VERSION || bad_line_in) begin
            result.verdict = rlp_pkg::VERDICT_MALFORMED;
         end else if (saw_question_in) begin
            result.verdict = rlp_pkg::VERDICT_QUERY;
         end else begin
            result.verdict = rlp_pkg::VERDICT_PATH;
         end
         // line done, back to a clean start
         phase_in        = PH_METHOD;
         seg_count_in    = '0;
         saw_question_in = 1'b0;
         bad_line_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_METHOD;
         seg_count_ff    <= '0;
         saw_question_ff <= 1'b0;
         bad_line_ff     <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         seg_count_ff    <= seg_count_in;
         saw_question_ff <= saw_question_in;
         bad_line_ff     <= bad_line_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/http_request_line_parser.sv
// top level of the http request line parser
//
//   channel  prefix  direction  word
//   input    req_    in         line_byte, line_end
//   result   rsp_    out        out_byte, segment, seg_offset, final_res, verdict
//   config   csr_    in         csr_index, csr_wdata
//
// one word in and one word out per cycle sustained while rsp_ready stays high;
// rsp_valid rises once an accepted word has moved from the input register into
// the result register, which waits while a held result is not yet drained.
// the parse state advances only when a word moves from the input register
// into the result register, so stalls on rsp_ready hold everything in place.
// synchronous reset returns the parse state to the method phase and the
// limits to 16, 1024 and 1024; no clearing pass is needed.
`default_nettype none

module http_request_line_parser #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_line_byte,
   input  wire logic                               req_line_end,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [7:0]                              rsp_out_byte,
   output logic [1:0]                              rsp_segment,
   output logic [15:0]                             rsp_seg_offset,
   output logic                                    rsp_final_res,
   output logic [1:0]                              rsp_verdict,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rlp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rlp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_end_ff;
   logic                rsp_valid_ff;
   rlp_pkg::result_type rsp_ff;
   rlp_pkg::result_type result;
   rlp_pkg::limits_type limits;
   logic                advance;
   logic                req_take;

   // word moves into the result register when that register is free or drains
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   rlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   rlp_parse_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .line_byte (in_byte_ff),
      .line_end  (in_end_ff),
      .limits    (limits),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_line_byte;
         in_end_ff  <= req_line_end;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_segment    = rsp_ff.segment;
   assign rsp_seg_offset = rsp_ff.seg_offset;
   assign rsp_final_res  = rsp_ff.final_res;
   assign rsp_verdict    = rsp_ff.verdict;

   // verdict only reported on the last word of a line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_res |-> rsp_verdict == rlp_pkg::VERDICT_PATH)
      else $error("verdict set on a non-final word");

   // a word held in the input register is not overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff)
         && $stable(in_end_ff))
      else $error("input register lost a waiting word");

   // an empty input register always takes a word
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stalled with empty input register");

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result register changed under stall");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// self-checking testbench for the http request line parser
`timescale 1ns / 1ps

module tb;

   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;

   typedef enum logic [1:0] {
      IN_METHOD  = 2'd0,
      IN_PATH    = 2'd1,
      IN_QUERY   = 2'd2,
      IN_VERSION = 2'd3
   } parse_phase_type;

   typedef struct {
      logic [7:0] line_byte;
      logic       line_end;
   } line_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [7:0]                         req_line_byte = '0;
   logic                               req_line_end = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [7:0]                         rsp_out_byte;
   logic [1:0]                         rsp_segment;
   logic [15:0]                        rsp_seg_offset;
   logic                               rsp_final_res;
   logic [1:0]                         rsp_verdict;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [rlp_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [rlp_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   http_request_line_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_line_byte  (req_line_byte),
      .req_line_end   (req_line_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_segment    (rsp_segment),
      .rsp_seg_offset (rsp_seg_offset),
      .rsp_final_res  (rsp_final_res),
      .rsp_verdict    (rsp_verdict),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   // limits as the parser holds them
   logic [rlp_pkg::METHOD_LIMIT_BITS-1:0] method_cap = rlp_pkg::METHOD_LIMIT_RESET;
   logic [rlp_pkg::PATH_LIMIT_BITS-1:0]   path_cap   = rlp_pkg::PATH_LIMIT_RESET;
   logic [rlp_pkg::PATH_LIMIT_BITS-1:0]   query_cap  = rlp_pkg::QUERY_LIMIT_RESET;

   // parse state of the line in progress
   parse_phase_type parse_phase = IN_METHOD;
   logic [15:0]     run_count   = '0;
   logic            saw_split   = 1'b0;
   logic            line_bad    = 1'b0;

   line_word_type       pending_words[$];
   rlp_pkg::result_type expected_labels[$];
   int                  words_queued = 0;
   int                  error_count = 0;
   int                  send_gap = 0;
   int                  recv_stall = 0;
   int                  hold_orders = 0;
   int                  hold_done = 0;
   int                  quiet_cycles = 0;
   bit                  send_idle_on = 1'b1;
   bit                  recv_idle_on = 1'b1;

   function automatic bit bad_length(input logic [15:0] len, input logic [12:0] cap);
      return len == 0 || len >= cap;
   endfunction

   function automatic rlp_pkg::result_type label_word(input logic [7:0] b, input logic last);
      rlp_pkg::result_type r;
      bit counted;
      counted      = 1'b0;
      r.out_byte   = b;
      r.segment    = rlp_pkg::SEG_VERSION;
      r.seg_offset = '0;
      r.final_res  = last;
      r.verdict    = rlp_pkg::VERDICT_PATH;
      case (parse_phase)
         IN_METHOD: begin
            if (b == rlp_pkg::CHAR_SPACE) begin
               if (bad_length(run_count, 13'(method_cap))) line_bad = 1'b1;
               parse_phase = IN_PATH;
               run_count   = '0;
            end else begin
               r.segment = rlp_pkg::SEG_METHOD;
               counted   = 1'b1;
            end
         end
         IN_PATH: begin
            if (b == rlp_pkg::CHAR_SPACE || b == rlp_pkg::CHAR_QUESTION) begin
               if (bad_length(run_count, path_cap)) line_bad = 1'b1;
               if (b == rlp_pkg::CHAR_QUESTION) begin
                  saw_split   = 1'b1;
                  parse_phase = IN_QUERY;
                  run_count   = '0;
               end else begin
                  parse_phase = IN_VERSION;
                  run_count   = 16'd1;
               end
            end else begin
               r.segment = rlp_pkg::SEG_PATH;
               counted   = 1'b1;
            end
         end
         IN_QUERY: begin
            if (b == rlp_pkg::CHAR_SPACE) begin
               if (bad_length(run_count, query_cap)) line_bad = 1'b1;
               parse_phase = IN_VERSION;
               run_count   = 16'd1;
            end else begin
               r.segment = rlp_pkg::SEG_QUERY;
               counted   = 1'b1;
            end
         end
         default: counted = 1'b1;
      endcase
      if (counted) begin
         r.seg_offset = run_count;
         if (run_count != '1) run_count = run_count + 16'd1;
      end
      if (last) begin
         if (parse_phase != IN_VERSION || line_bad) r.verdict = rlp_pkg::VERDICT_MALFORMED;
         else if (saw_split) r.verdict = rlp_pkg::VERDICT_QUERY;
         parse_phase = IN_METHOD;
         run_count   = '0;
         saw_split   = 1'b0;
         line_bad    = 1'b0;
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      line_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_labels.push_back(label_word(req_line_byte, req_line_end));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (send_idle_on && pending_words.size() > 0 && $urandom_range(0, 7) == 0) begin
               send_gap  <= $urandom_range(0, 12);
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               w = pending_words.pop_front();
               req_valid     <= 1'b1;
               req_line_byte <= w.line_byte;
               req_line_end  <= w.line_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rlp_pkg::result_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall <= 0;
         hold_done  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_labels.size() == 0) begin
               if (error_count < 10)
                  $display("tb: word %h arrived with nothing expected", rsp_out_byte);
               error_count++;
            end else begin
               want = expected_labels.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_segment !== want.segment ||
                   rsp_seg_offset !== want.seg_offset || rsp_final_res !== want.final_res ||
                   rsp_verdict !== want.verdict) begin
                  if (error_count < 10)
                     $display("tb: mismatch exp %h/%0d/%0d/%0b/%0d got %h/%0d/%0d/%0b/%0d",
                              want.out_byte, want.segment, want.seg_offset, want.final_res,
                              want.verdict, rsp_out_byte, rsp_segment, rsp_seg_offset,
                              rsp_final_res, rsp_verdict);
                  error_count++;
               end
            end
         end
         if (hold_done != hold_orders) begin
            hold_done  <= hold_orders;
            recv_stall <= HOLD_CYCLES;
            rsp_ready  <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready  <= 1'b0;
         end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
            recv_stall <= $urandom_range(0, 12);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles where no channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] text_byte(input bit allow_question);
      logic [7:0] b;
      if (allow_question && $urandom_range(0, 9) == 0) return rlp_pkg::CHAR_QUESTION;
      do b = 8'($urandom_range(0, 255));
      while (b == rlp_pkg::CHAR_SPACE || b == rlp_pkg::CHAR_QUESTION);
      return b;
   endfunction

   function automatic logic [7:0] loose_byte();
      case ($urandom_range(0, 9))
         0, 1: return rlp_pkg::CHAR_SPACE;
         2: return rlp_pkg::CHAR_QUESTION;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly short segments, often right at a small limit
   function automatic int seg_len(input int lim);
      int r;
      r = $urandom_range(0, 99);
      if (lim <= 40 && r < 40) return lim - 1 + int'($urandom_range(0, 1));
      return int'($urandom_range(1, 8));
   endfunction

   task automatic push_word(input logic [7:0] b, input logic last);
      line_word_type w;
      w.line_byte = b;
      w.line_end  = last;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1);
   endtask

   // qlen below zero leaves out the question mark
   task automatic push_request(input int mlen, input bit sp1, input int plen, input int qlen,
                               input bit sp2, input int vlen);
      logic [7:0] line_q[$];
      repeat (mlen) line_q.push_back(text_byte(1'b1));
      if (sp1) begin
         line_q.push_back(rlp_pkg::CHAR_SPACE);
         repeat (plen) line_q.push_back(text_byte(1'b0));
         if (qlen >= 0) begin
            line_q.push_back(rlp_pkg::CHAR_QUESTION);
            repeat (qlen) line_q.push_back(text_byte(1'b1));
         end
         if (sp2) begin
            line_q.push_back(rlp_pkg::CHAR_SPACE);
            repeat (vlen) line_q.push_back(loose_byte());
         end
      end
      if (line_q.size() == 0) line_q.push_back(text_byte(1'b0));
      foreach (line_q[i]) push_word(line_q[i], i == line_q.size() - 1);
   endtask

   task automatic queue_random_lines(input int budget);
      int start;
      int kind;
      int n;
      start = words_queued;
      while (words_queued - start < budget) begin
         kind = int'($urandom_range(0, 9));
         if (kind < 7) begin
            push_request(seg_len(method_cap), 1'b1, seg_len(path_cap),
                         $urandom_range(0, 1) ? seg_len(query_cap) : -1, 1'b1,
                         int'($urandom_range(0, 6)));
         end else if (kind == 7) begin
            push_request(int'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         int'($urandom_range(0, 3)), int'($urandom_range(0, 3)) - 1,
                         1'($urandom_range(0, 1)), int'($urandom_range(0, 3)));
         end else begin
            n = int'($urandom_range(1, 12));
            for (int i = 0; i < n; i++) push_word(loose_byte(), i == n - 1);
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_labels.size() != 0);
   endtask

   task automatic write_limit(input rlp_pkg::csr_index_type idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= rlp_pkg::CSR_DATA_BITS'(value);
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         rlp_pkg::CSR_METHOD_LIMIT: method_cap = rlp_pkg::METHOD_LIMIT_BITS'(value);
         rlp_pkg::CSR_PATH_LIMIT:   path_cap   = rlp_pkg::PATH_LIMIT_BITS'(value);
         rlp_pkg::CSR_QUERY_LIMIT:  query_cap  = rlp_pkg::PATH_LIMIT_BITS'(value);
         default: ;
      endcase
   endtask

   task automatic set_limits(input int m, input int p, input int q);
      wait_drained();
      repeat (4) @(posedge clock);
      write_limit(rlp_pkg::CSR_METHOD_LIMIT, m);
      write_limit(rlp_pkg::CSR_PATH_LIMIT, p);
      write_limit(rlp_pkg::CSR_QUERY_LIMIT, q);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short lines with default limits
      push_text("A B ");
      push_word(8'hFF, 1'b0);
      push_word(rlp_pkg::CHAR_SPACE, 1'b0);
      push_word(8'h00, 1'b0);
      push_word(rlp_pkg::CHAR_QUESTION, 1'b0);
      push_word(8'h80, 1'b0);
      push_word(rlp_pkg::CHAR_SPACE, 1'b0);
      push_word(rlp_pkg::CHAR_QUESTION, 1'b0);
      push_word(rlp_pkg::CHAR_SPACE, 1'b1);
      push_text(" ");
      push_text("A");
      push_text("A ?B ");
      push_text("A B? ");
      push_text("A B");
      wait_drained();

      // sender keeps offering while the receiver holds off
      send_idle_on = 1'b0;
      queue_random_lines(160);
      hold_orders++;
      wait_drained();
      send_idle_on = 1'b1;

      set_limits(1, 1, 1);
      queue_random_lines(80);

      // segments just below and right at the limits
      set_limits(64, 24, 24);
      push_request(63, 1'b1, 23, 23, 1'b1, 2);
      push_request(64, 1'b1, 24, 24, 1'b1, 2);
      queue_random_lines(60);

      set_limits(64, 4096, 4096);
      queue_random_lines(80);

      set_limits($urandom_range(1, 10), $urandom_range(1, 16), $urandom_range(1, 16));
      queue_random_lines(80);
      set_limits($urandom_range(1, 10), $urandom_range(1, 16), $urandom_range(1, 16));
      queue_random_lines(80);
      set_limits($urandom_range(1, 64), $urandom_range(1, 4096), $urandom_range(1, 4096));
      queue_random_lines(80);

      // last stretch runs without idling
      set_limits(rlp_pkg::METHOD_LIMIT_RESET, rlp_pkg::PATH_LIMIT_RESET,
                 rlp_pkg::QUERY_LIMIT_RESET);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      queue_random_lines(100);

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_labels.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: http_request_line_parser.f
hw/rtl/rlp_pkg.sv
hw/rtl/rlp_csr.sv
hw/rtl/rlp_parse_core.sv
hw/rtl/http_request_line_parser.sv
verif/tb.sv
